/* sv/lir_pkg.sv */
// Shared constants, register codes and controller/datapath handshake types
// for the linear interpolation resampler. No dependencies.
package lir_pkg;

  // Default widths
  localparam int unsigned SAMPLE_BITS_DEF      = 24;
  localparam int unsigned FRAC_BITS_DEF        = 16;
  localparam int unsigned FRAME_COUNT_BITS_DEF = 30;

  // Fixed field widths
  localparam int unsigned STEP_BITS    = 26;
  localparam int unsigned CFG_IDX_BITS = 2;

  // Output frames per source sample, at most
  localparam int unsigned MAX_RESULTS  = 64;
  localparam int unsigned RUN_CNT_BITS = $clog2(MAX_RESULTS);

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_RATIO       = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEST_FRAME_COUNT = CFG_IDX_BITS'(1);

  // Controller to datapath
  typedef struct packed {
    logic load;      // latch a new source word
    logic emit;      // load the output register with the current frame
    logic finalize;  // close out the current source word
  } lir_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic interp_ok; // an interpolated frame is due
    logic tail_ok;   // a tail frame (copy of last sample) is due
    logic more;      // another frame follows the current one
  } lir_stat_t;

endpackage

/* sv/lir_if.sv */
// Stream and configuration interfaces of the resampler.
// Depends on lir_pkg for default widths.
interface lir_in_if
  import lir_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          last_of_plane;

  modport source (output valid, sample_in, last_of_plane, input ready);
  modport sink   (input valid, sample_in, last_of_plane, output ready);
endinterface

interface lir_out_if
  import lir_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          last_of_run;
  logic                          plane_done;

  modport source (output valid, sample_out, last_of_run, plane_done, input ready);
  modport sink   (input valid, sample_out, last_of_run, plane_done, output ready);
endinterface

interface lir_cfg_if
  import lir_pkg::*;
#(
  parameter int unsigned DATA_BITS = FRAME_COUNT_BITS_DEF + 1
);
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [DATA_BITS-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/lir_ctrl.sv */
// Resampler controller: sequences take / emit / finalize for each source word
// and owns the output valid bit. Depends on lir_pkg.
module lir_ctrl
  import lir_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  lir_stat_t stat_i,
  output lir_cmd_t  cmd_o
);

  typedef enum logic {IDLE, RUN} state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;
  logic   due;

  assign in_ready_o  = (state_q == IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign due         = stat_i.interp_ok || stat_i.tail_ok;

  // Commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      IDLE: begin
        cmd_o.load = in_valid_i;
      end
      RUN: begin
        if (!due) begin
          cmd_o.finalize = 1'b1;
        end else if (slot_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.finalize = !stat_i.more;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        IDLE: if (cmd_o.load) state_q <= RUN;
        RUN:  if (cmd_o.finalize) state_q <= IDLE;
        default: state_q <= IDLE;
      endcase
    end
  end

endmodule

/* sv/lir_dp.sv */
// Resampler datapath: config registers, plane state, phase accumulator,
// interpolator and output register. Depends on lir_pkg.
module lir_dp
  import lir_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS      = SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS        = FRAC_BITS_DEF,
  parameter int unsigned FRAME_COUNT_BITS = FRAME_COUNT_BITS_DEF,
  parameter int unsigned CFG_DATA_BITS    = FRAME_COUNT_BITS_DEF + 1
)(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  logic                          last_of_plane_i,
  input  lir_cmd_t                      cmd_i,
  output lir_stat_t                     stat_o,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic                          last_of_run_o,
  output logic                          plane_done_o
);

  localparam int unsigned CW    = FRAME_COUNT_BITS + 1;
  localparam int unsigned PW    = CW + FRAC_BITS;
  localparam int unsigned PRODW = SAMPLE_BITS + FRAC_BITS + 2;
  localparam logic signed [PRODW-1:0] HALF = PRODW'(1) << (FRAC_BITS - 1);

  // Config
  logic [STEP_BITS-1:0] step_q;
  logic [CW-1:0]        dest_q;

  // Plane state
  logic signed [SAMPLE_BITS-1:0] prev_q;
  logic [CW-1:0]                 in_cnt_q, out_cnt_q;
  logic [PW-1:0]                 phase_q, phase_nx_q;

  // Current source word
  logic signed [SAMPLE_BITS-1:0] cur_q;
  logic signed [SAMPLE_BITS:0]   diff_q;
  logic                          last_q;
  logic [RUN_CNT_BITS-1:0]       n_q;

  // Output register
  logic [SAMPLE_BITS-1:0] sample_q;
  logic                   run_end_q, plane_done_q;

  logic [PW-1:0]             step_w;
  logic [CW-1:0]             idx, nx_idx, out_inc;
  logic [FRAC_BITS-1:0]      frac;
  logic                      out_lt, out_inc_lt, at_cur;
  logic signed [PRODW-1:0]   prod, rnd;
  logic [SAMPLE_BITS-1:0]    lerp, val;

  assign step_w  = PW'(step_q);
  assign idx     = phase_q[PW-1:FRAC_BITS];
  assign nx_idx  = phase_nx_q[PW-1:FRAC_BITS];
  assign frac    = phase_q[FRAC_BITS-1:0];
  assign out_inc = out_cnt_q + CW'(1);

  // Frame availability
  assign out_lt     = out_cnt_q < dest_q;
  assign out_inc_lt = ({1'b0, out_cnt_q} + (CW + 1)'(1)) < {1'b0, dest_q};

  assign stat_o.interp_ok = (in_cnt_q != '0) && out_lt && (idx < in_cnt_q);
  assign stat_o.tail_ok   = last_q && out_lt;
  assign stat_o.more      = (n_q != RUN_CNT_BITS'(MAX_RESULTS - 1)) && out_inc_lt &&
                            (last_q || (stat_o.interp_ok && (nx_idx < in_cnt_q)));

  // Interpolator: prev + round((cur - prev) * frac)
  assign prod   = diff_q * $signed({1'b0, frac});
  assign rnd    = (prod + HALF) >>> FRAC_BITS;
  assign lerp   = prev_q + rnd[SAMPLE_BITS-1:0];
  assign at_cur = (idx == (in_cnt_q - CW'(1)));

  always_comb begin
    priority if (stat_o.interp_ok) begin
      val = at_cur ? lerp : prev_q;
    end else begin
      val = cur_q;
    end
  end

  // Config and plane state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= STEP_BITS'(1) << FRAC_BITS;
      dest_q     <= CW'(1);
      prev_q     <= '0;
      in_cnt_q   <= '0;
      out_cnt_q  <= '0;
      phase_q    <= '0;
      phase_nx_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_STEP_RATIO:       step_q <= cfg_data_i[STEP_BITS-1:0];
          CFG_DEST_FRAME_COUNT: dest_q <= cfg_data_i[CW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        phase_nx_q <= phase_q + step_w;
      end
      // Plane end clears prev, the counters and the phase; otherwise advance and close the word
      if (cmd_i.finalize && last_q) begin
        prev_q    <= '0;
        in_cnt_q  <= '0;
        out_cnt_q <= '0;
        phase_q   <= '0;
      end else begin
        if (cmd_i.emit) begin
          out_cnt_q <= out_inc;
          if (stat_o.interp_ok) begin
            phase_q    <= phase_nx_q;
            phase_nx_q <= phase_nx_q + step_w;
          end
        end
        if (cmd_i.finalize) begin
          prev_q <= cur_q;
          if (in_cnt_q != '1) in_cnt_q <= in_cnt_q + CW'(1);
        end
      end
    end
  end

  // Source word and output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_q  <= sample_in_i;
      last_q <= last_of_plane_i;
      diff_q <= {sample_in_i[SAMPLE_BITS-1], sample_in_i} - {prev_q[SAMPLE_BITS-1], prev_q};
      n_q    <= '0;
    end
    if (cmd_i.emit) begin
      n_q          <= n_q + RUN_CNT_BITS'(1);
      sample_q     <= val;
      run_end_q    <= !stat_o.more;
      plane_done_q <= (out_inc == dest_q) || (!stat_o.more && last_q);
    end
  end

  assign sample_out_o  = sample_q;
  assign last_of_run_o = run_end_q;
  assign plane_done_o  = plane_done_q;

endmodule

/* sv/linear_interp_resampler_core.sv */
// Linear interpolation sample rate converter, top level.
// Depends on lir_pkg, lir_if, lir_ctrl and lir_dp.
//
// Feed the samples of one channel plane in order, marking the final one with
// last_of_plane; output frame i lies at source position i*step_ratio (16
// fraction bits by default) and is prev + (cur - prev)*frac, rounded to
// nearest. The last sample of a plane fills up to dest_frame_count with copies
// of itself and clears the plane state. A new source word is taken only once
// the previous one is finished; the output frames that a word causes, up to 64
// per word, are paced by the output register, and back pressure stretches the
// run. Write the registers only while idle.
module linear_interp_resampler_core
  import lir_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS      = SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS        = FRAC_BITS_DEF,
  parameter int unsigned FRAME_COUNT_BITS = FRAME_COUNT_BITS_DEF,
  parameter int unsigned CFG_DATA_BITS    =
    (FRAME_COUNT_BITS + 1 > STEP_BITS) ? FRAME_COUNT_BITS + 1 : STEP_BITS
)(
  input  logic       clk_i,
  input  logic       rst_ni,
  lir_cfg_if.sink    cfg_i,
  lir_in_if.sink     in_i,
  lir_out_if.source  out_o
);

  lir_cmd_t  cmd;
  lir_stat_t stat;

  // Registers accept every write
  assign cfg_i.ready = 1'b1;

  lir_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lir_dp #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .FRAC_BITS        (FRAC_BITS),
    .FRAME_COUNT_BITS (FRAME_COUNT_BITS),
    .CFG_DATA_BITS    (CFG_DATA_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .sample_in_i     (in_i.sample_in),
    .last_of_plane_i (in_i.last_of_plane),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .sample_out_o    (out_o.sample_out),
    .last_of_run_o   (out_o.last_of_run),
    .plane_done_o    (out_o.plane_done)
  );

endmodule
